@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the router RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ORC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition must never be true at a clock edge out of reset.
`define ORC_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ hw/rtl/orc_pkg.sv @@
// Package for the orthogonal connector router: widths, reset values and the
// route record passed from the front end through the queue to the back end.
// No dependencies.
package orc_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int STUB_W         = 10;
  localparam logic [STUB_W-1:0] STUB_RESET = STUB_W'(10);

  localparam int OUT_W   = 19;
  localparam int OUT_MAX = 262143;
  localparam int OUT_MIN = -262144;

  localparam int MAX_PTS = 6;
  localparam int CNT_W   = 3;

  // Queue depth between front and back end; must be a power of two.
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [MAX_PTS-1:0][OUT_W-1:0] px;
    logic [MAX_PTS-1:0][OUT_W-1:0] py;
    logic [CNT_W-1:0]              cnt;
  } route_t;

endpackage

@@ hw/rtl/orc_if.sv @@
// Handshake interfaces of the router: route requests, corner points and the
// stub length configuration write. Depends on orc_pkg.
interface orc_in_if #(
  parameter int COORD_BITS = orc_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [2:0]            start_dir;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic signed [2:0]            end_dir;

  modport source (
    output valid, start_x, start_y, start_dir, end_x, end_y, end_dir,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, start_dir, end_x, end_y, end_dir,
    output ready
  );
endinterface

interface orc_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [orc_pkg::OUT_W-1:0] point_x;
  logic signed [orc_pkg::OUT_W-1:0] point_y;
  logic                            last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

interface orc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [orc_pkg::STUB_W-1:0]   stub_length;

  modport source (output valid, stub_length, input ready);
  modport sink (input valid, stub_length, output ready);
endinterface

@@ hw/rtl/orc_front.sv @@
// Front end of the router: holds the stub length register, accepts route
// requests and computes all corner points in a six-stage pipeline.
// Depends on orc_pkg and orc_if.sv.
module orc_front #(
  parameter int COORD_BITS = orc_pkg::COORD_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  orc_in_if.sink         in_i,
  orc_cfg_if.sink        cfg_i,
  input  logic           q_ready_i,
  output logic           push_o,
  output orc_pkg::route_t route_o
);

  localparam int MagW = (COORD_BITS > 13) ? COORD_BITS : 13;
  localparam int W    = MagW + 6;

  typedef logic signed [W-1:0] val_t;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_e;

  typedef enum logic [1:0] {
    ROUTE_SAME,
    ROUTE_OPP,
    ROUTE_NEAR,
    ROUTE_FAR
  } route_kind_e;

  typedef struct packed {
    logic none;
    logic away;
    dir_e s1;
    dir_e s2;
    val_t x0;
    val_t y0;
    val_t x1;
    val_t y1;
    val_t x2;
    val_t y2;
    val_t len;
  } geo_t;

  localparam val_t SatHi = val_t'(orc_pkg::OUT_MAX);
  localparam val_t SatLo = val_t'(orc_pkg::OUT_MIN);

  function automatic val_t to_half(logic signed [COORD_BITS-1:0] c);
    val_t v;
    v = val_t'(c);
    return v <<< 1;
  endfunction

  function automatic logic is_pos(val_t v);
    return !v[W-1] && (v != '0);
  endfunction

  function automatic val_t abs_val(val_t v);
    return v[W-1] ? -v : v;
  endfunction

  function automatic logic is_vert(dir_e d);
    return (d == DIR_UP) || (d == DIR_DOWN);
  endfunction

  // True when the offset (dx, dy) points against direction d.
  function automatic logic opposes(dir_e d, val_t dx, val_t dy);
    logic r;
    unique case (d)
      DIR_UP:    r = is_pos(dy);
      DIR_LEFT:  r = is_pos(dx);
      DIR_DOWN:  r = dy[W-1];
      DIR_RIGHT: r = dx[W-1];
      default:   r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic dir_e turn_dir(dir_e d, logic pos);
    dir_e r;
    unique case (d) inside
      DIR_UP, DIR_DOWN:    r = pos ? DIR_RIGHT : DIR_LEFT;
      DIR_LEFT, DIR_RIGHT: r = pos ? DIR_DOWN : DIR_UP;
      default:             r = DIR_UP;
    endcase
    return r;
  endfunction

  function automatic val_t move_x(val_t base, dir_e d, val_t amt);
    val_t r;
    unique case (d) inside
      DIR_LEFT:         r = base - amt;
      DIR_RIGHT:        r = base + amt;
      DIR_UP, DIR_DOWN: r = base;
      default:          r = base;
    endcase
    return r;
  endfunction

  function automatic val_t move_y(val_t base, dir_e d, val_t amt);
    val_t r;
    unique case (d) inside
      DIR_UP:              r = base - amt;
      DIR_DOWN:            r = base + amt;
      DIR_LEFT, DIR_RIGHT: r = base;
      default:             r = base;
    endcase
    return r;
  endfunction

  function automatic logic [orc_pkg::OUT_W-1:0] sat(val_t v);
    logic [orc_pkg::OUT_W-1:0] r;
    if (v > SatHi) begin
      r = SatHi[orc_pkg::OUT_W-1:0];
    end else if (v < SatLo) begin
      r = SatLo[orc_pkg::OUT_W-1:0];
    end else begin
      r = v[orc_pkg::OUT_W-1:0];
    end
    return r;
  endfunction

  logic [orc_pkg::STUB_W-1:0] stub_q;

  logic adv;
  logic a_vld_q, b_vld_q, c_vld_q, d_vld_q, e_vld_q, f_vld_q;

  geo_t a_d, a_q, b_d, b_q, c_q, d_q, e_q, f_q;
  val_t a_dx_q, a_dy_q, c_dx_q, c_dy_q;

  route_kind_e d_kind_d, d_kind_q, e_kind_q, f_kind_q;
  dir_e        d_t_d, d_t_q, e_t_q, f_t_q;
  val_t        d_along_d, d_along_q, d_lat_d, d_lat_q;
  val_t        e_delta_d, e_delta_q, e_alpha_q, f_alpha_q;
  val_t        f_p1x_q, f_p1y_q, f_p2x_q, f_p2y_q;

  logic b_pos, d_same, d_opp;
  val_t d_adx, d_ady, f_amt2;
  val_t p3x, p3y;

  logic [orc_pkg::OUT_W-1:0] sx0, sy0, sx1, sy1, sp1x, sp1y, sp2x, sp2y;
  logic [orc_pkg::OUT_W-1:0] sp3x, sp3y, sx2, sy2;
  logic [orc_pkg::MAX_PTS-1:0][orc_pkg::OUT_W-1:0] tx, ty;
  logic [orc_pkg::CNT_W-1:0] base_cnt;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stub_q <= orc_pkg::STUB_RESET;
    end else if (cfg_i.valid) begin
      stub_q <= cfg_i.stub_length;
    end
  end

  // Items with no direction travel down the pipe and are dropped at the end.
  assign adv        = !f_vld_q || f_q.none || q_ready_i;
  assign in_i.ready = adv;
  assign push_o     = f_vld_q && !f_q.none && q_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= in_i.valid;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
      e_vld_q <= d_vld_q;
      f_vld_q <= e_vld_q;
    end
  end

  always_comb begin
    a_d.none = in_i.start_dir[2] | in_i.end_dir[2];
    a_d.away = 1'b0;
    a_d.s1   = dir_e'(in_i.start_dir[1:0]);
    a_d.s2   = dir_e'(in_i.end_dir[1:0]);
    a_d.x1   = to_half(in_i.start_x);
    a_d.y1   = to_half(in_i.start_y);
    a_d.x0   = a_d.x1;
    a_d.y0   = a_d.y1;
    a_d.x2   = to_half(in_i.end_x);
    a_d.y2   = to_half(in_i.end_y);
    a_d.len  = val_t'({1'b0, stub_q, 1'b0});
  end

  // A start that faces away from the end leaves by one stub and turns.
  always_comb begin
    b_d      = a_q;
    b_pos    = is_vert(a_q.s1) ? !a_dx_q[W-1] : !a_dy_q[W-1];
    b_d.away = opposes(a_q.s1, a_dx_q, a_dy_q);
    b_d.x0   = a_q.x1;
    b_d.y0   = a_q.y1;
    if (b_d.away) begin
      b_d.s1 = turn_dir(a_q.s1, b_pos);
      b_d.x1 = move_x(a_q.x1, a_q.s1, a_q.len);
      b_d.y1 = move_y(a_q.y1, a_q.s1, a_q.len);
    end
  end

  always_comb begin
    d_same    = c_q.s1 == c_q.s2;
    d_opp     = !d_same && (c_q.s1[0] == c_q.s2[0]);
    d_adx     = abs_val(c_dx_q);
    d_ady     = abs_val(c_dy_q);
    d_along_d = is_vert(c_q.s1) ? d_ady : d_adx;
    d_lat_d   = is_vert(c_q.s1) ? d_adx : d_ady;
    d_t_d     = turn_dir(c_q.s1, is_vert(c_q.s1) ? is_pos(c_dx_q) : is_pos(c_dy_q));
    if (d_same) begin
      d_kind_d = ROUTE_SAME;
    end else if (d_opp) begin
      d_kind_d = ROUTE_OPP;
    end else if (opposes(c_q.s2, c_dx_q, c_dy_q)) begin
      d_kind_d = ROUTE_NEAR;
    end else begin
      d_kind_d = ROUTE_FAR;
    end
  end

  always_comb begin
    unique case (d_kind_q)
      ROUTE_SAME: e_delta_d = d_along_q + d_q.len;
      ROUTE_NEAR: e_delta_d = d_along_q;
      ROUTE_OPP:  e_delta_d = d_along_q >>> 1;
      ROUTE_FAR:  e_delta_d = d_along_q >>> 1;
      default:    e_delta_d = d_along_q;
    endcase
  end

  assign f_amt2 = (e_kind_q == ROUTE_OPP) ? e_delta_q : e_q.len;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q       <= a_d;
      a_dx_q    <= a_d.x2 - a_d.x1;
      a_dy_q    <= a_d.y2 - a_d.y1;
      b_q       <= b_d;
      c_q       <= b_q;
      c_dx_q    <= b_q.x2 - b_q.x1;
      c_dy_q    <= b_q.y2 - b_q.y1;
      d_q       <= c_q;
      d_kind_q  <= d_kind_d;
      d_t_q     <= d_t_d;
      d_along_q <= d_along_d;
      d_lat_q   <= d_lat_d;
      e_q       <= d_q;
      e_kind_q  <= d_kind_q;
      e_t_q     <= d_t_q;
      e_delta_q <= e_delta_d;
      e_alpha_q <= d_lat_q + d_q.len;
      f_q       <= e_q;
      f_kind_q  <= e_kind_q;
      f_t_q     <= e_t_q;
      f_alpha_q <= e_alpha_q;
      f_p1x_q   <= move_x(e_q.x1, e_q.s1, e_delta_q);
      f_p1y_q   <= move_y(e_q.y1, e_q.s1, e_delta_q);
      f_p2x_q   <= move_x(e_q.x2, e_q.s2, f_amt2);
      f_p2y_q   <= move_y(e_q.y2, e_q.s2, f_amt2);
    end
  end

  assign p3x = move_x(f_p1x_q, f_t_q, f_alpha_q);
  assign p3y = move_y(f_p1y_q, f_t_q, f_alpha_q);

  assign sx0  = sat(f_q.x0);
  assign sy0  = sat(f_q.y0);
  assign sx1  = sat(f_q.x1);
  assign sy1  = sat(f_q.y1);
  assign sp1x = sat(f_p1x_q);
  assign sp1y = sat(f_p1y_q);
  assign sp2x = sat(f_p2x_q);
  assign sp2y = sat(f_p2y_q);
  assign sp3x = sat(p3x);
  assign sp3y = sat(p3y);
  assign sx2  = sat(f_q.x2);
  assign sy2  = sat(f_q.y2);

  always_comb begin
    for (int i = 0; i < orc_pkg::MAX_PTS; i++) begin
      tx[i] = sx2;
      ty[i] = sy2;
    end
    tx[0] = sx1;
    ty[0] = sy1;
    tx[1] = sp1x;
    ty[1] = sp1y;
    unique case (f_kind_q)
      ROUTE_SAME, ROUTE_OPP: begin
        tx[2]    = sp2x;
        ty[2]    = sp2y;
        base_cnt = orc_pkg::CNT_W'(4);
      end
      ROUTE_NEAR: begin
        base_cnt = orc_pkg::CNT_W'(3);
      end
      ROUTE_FAR: begin
        tx[2]    = sp3x;
        ty[2]    = sp3y;
        tx[3]    = sp2x;
        ty[3]    = sp2y;
        base_cnt = orc_pkg::CNT_W'(5);
      end
      default: begin
        base_cnt = orc_pkg::CNT_W'(3);
      end
    endcase

    route_o.cnt = base_cnt + orc_pkg::CNT_W'(f_q.away);
    if (f_q.away) begin
      route_o.px[0] = sx0;
      route_o.py[0] = sy0;
      for (int i = 1; i < orc_pkg::MAX_PTS; i++) begin
        route_o.px[i] = tx[i-1];
        route_o.py[i] = ty[i-1];
      end
    end else begin
      route_o.px = tx;
      route_o.py = ty;
    end
  end

endmodule

@@ hw/rtl/orc_fifo.sv @@
// Short queue of finished routes between the front and back end.
// Depends on orc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module orc_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  orc_pkg::route_t data_i,
  output logic            ready_o,
  input  logic            pop_i,
  output logic            vld_o,
  output orc_pkg::route_t data_o
);

  localparam int PtrW = (orc_pkg::QUEUE_DEPTH > 1) ? $clog2(orc_pkg::QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(orc_pkg::QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(orc_pkg::QUEUE_DEPTH);

  orc_pkg::route_t mem_q [orc_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign ready_o = cnt_q != FullCnt;
  assign vld_o   = cnt_q != '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  `ORC_ASSERT_NEVER(a_cnt_range, cnt_q > FullCnt, "Queue count exceeds its depth.")
  `ORC_ASSERT(a_push_room, push_i |-> (cnt_q != FullCnt), "Route pushed into a full queue.")
  `ORC_ASSERT(a_pop_data, pop_i |-> (cnt_q != '0), "Route popped from an empty queue.")
  `ORC_ASSERT(a_cnt_up, (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + CntW'(1)), "Count lost a push.")

endmodule

@@ hw/rtl/orc_back.sv @@
// Back end of the router: walks the route at the head of the queue and
// sends its corner points one per cycle, while the output is ready, through an output register.
// Depends on orc_pkg, orc_if.sv and assert_macros.svh.
`include "assert_macros.svh"

module orc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_vld_i,
  input  orc_pkg::route_t q_data_i,
  output logic            pop_o,
  orc_out_if.source       out_o
);

  logic                        vld_q, last_q;
  logic [orc_pkg::OUT_W-1:0]   x_q, y_q;
  logic [orc_pkg::CNT_W-1:0]   idx_q;
  logic                        out_free, load, is_last;

  assign out_free = !vld_q || out_o.ready;
  assign load     = q_vld_i && out_free;
  assign is_last  = idx_q == (q_data_i.cnt - orc_pkg::CNT_W'(1));
  assign pop_o    = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else begin
      if (out_free) begin
        vld_q <= q_vld_i;
      end
      if (load) begin
        idx_q <= is_last ? '0 : idx_q + orc_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      x_q    <= q_data_i.px[idx_q];
      y_q    <= q_data_i.py[idx_q];
      last_q <= is_last;
    end
  end

  assign out_o.valid      = vld_q;
  assign out_o.point_x    = x_q;
  assign out_o.point_y    = y_q;
  assign out_o.last_point = last_q;

  `ORC_ASSERT(a_idx_in_route, q_vld_i |-> (idx_q < q_data_i.cnt), "Point index past route end.")
  `ORC_ASSERT(a_idx_idle, !q_vld_i |-> (idx_q == '0), "Point index not rewound.")
  `ORC_ASSERT(a_pop_last, pop_o |=> (out_o.valid && out_o.last_point), "Route popped early.")

endmodule

@@ hw/rtl/orthogonal_connector_router_top.sv @@
// Orthogonal connector router: a route request enters the front pipeline
// at up to one item per cycle unless the queue is full, and its corner
// points leave one per cycle while the output is ready, three to six per
// route. Requests with a missing direction produce no points. A request's
// first point passes the front pipeline stages, the queue and the output register.
// Points are in half units, saturated to 19 bits; stub_length resets to 10.
// Depends on orc_pkg, orc_if.sv, orc_front, orc_fifo and orc_back.
module orthogonal_connector_router_top #(
  parameter int COORD_BITS = orc_pkg::COORD_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  orc_in_if.sink    in_i,
  orc_out_if.source out_o,
  orc_cfg_if.sink   cfg_i
);

  logic            push, q_ready, q_vld, pop;
  orc_pkg::route_t push_data, head_data;

  orc_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .cfg_i     (cfg_i),
    .q_ready_i (q_ready),
    .push_o    (push),
    .route_o   (push_data)
  );

  orc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .ready_o (q_ready),
    .pop_i   (pop),
    .vld_o   (q_vld),
    .data_o  (head_data)
  );

  orc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_vld_i  (q_vld),
    .q_data_i (head_data),
    .pop_o    (pop),
    .out_o    (out_o)
  );

endmodule
